### rtl/core/resp_command_parser_macros.svh
// Assertion macros shared by the parser RTL files.
// Each use expects clk_i and rst_ni in the enclosing module.
`ifndef RESP_COMMAND_PARSER_MACROS_SVH
`define RESP_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rcp_pkg.sv
// Types and constants shared by the command parser modules.
// No dependencies.
`timescale 1ns / 1ps

package rcp_pkg;

  localparam int unsigned ARG_REG_W = 20;
  localparam int unsigned LEN_REG_W = 30;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [ARG_REG_W-1:0] MAX_ARGS_RST    = 20'hF_FFFF;
  localparam logic [LEN_REG_W-1:0] MAX_PAYLOAD_RST = 30'd536870912;

  // Register select: paddr bit 2 (word index)
  localparam logic REG_MAX_ARGS    = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_COUNT   = 3'd1,
    PH_BULK    = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_FIRST   = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_SKIP    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_ERROR   = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    ERR_BAD_ARRAY = 2'd0,
    ERR_BAD_BULK  = 2'd1,
    ERR_NUMBER    = 2'd2,
    ERR_LIMIT     = 2'd3
  } err_code_e;

  typedef struct packed {
    logic [ARG_REG_W-1:0] max_arguments;
    logic [LEN_REG_W-1:0] max_payload_length;
  } rcp_cfg_t;

  typedef struct packed {
    err_code_e   error_code;
    logic [31:0] command_length;
    logic [19:0] argument_count;
    logic        command_end;
    logic        argument_end;
    logic [19:0] argument_index;
    logic [7:0]  payload_byte;
    event_kind_e event_kind;
  } rcp_result_t;

endpackage

### rtl/core/rcp_apb_regs.sv
// APB register file holding the two parser limits.
// Depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rcp_pkg::rcp_cfg_t          cfg_o
);
  import rcp_pkg::*;

  rcp_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_ARGS:    cfg_d.max_arguments      = pwdata[ARG_REG_W-1:0];
        REG_MAX_PAYLOAD: cfg_d.max_payload_length = pwdata[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_ARGS:    prdata = 32'(cfg_q.max_arguments);
      REG_MAX_PAYLOAD: prdata = 32'(cfg_q.max_payload_length);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_arguments      <= MAX_ARGS_RST;
      cfg_q.max_payload_length <= MAX_PAYLOAD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/rcp_parser.sv
// Parse state machine: one byte per step, produces one result per byte.
// Depends on rcp_pkg and resp_command_parser_macros.svh.
`timescale 1ns / 1ps
`include "resp_command_parser_macros.svh"

module rcp_parser #(
  parameter int unsigned ARG_COUNT_BITS = 20,
  parameter int unsigned LENGTH_BITS    = 30
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  rcp_pkg::rcp_cfg_t    cfg_i,
  output rcp_pkg::rcp_result_t result_o
);
  import rcp_pkg::*;

  localparam int unsigned CntW    = ARG_COUNT_BITS;
  localparam int unsigned LimArgW = (ARG_COUNT_BITS < ARG_REG_W) ? ARG_COUNT_BITS : ARG_REG_W;
  localparam int unsigned LenW    = (LENGTH_BITS < LEN_REG_W) ? LENGTH_BITS : LEN_REG_W;
  localparam int unsigned NumW    = (LimArgW > LenW) ? LimArgW : LenW;
  localparam int unsigned VW      = NumW + 4;
  localparam logic [31:0] ArgMask =
    (ARG_COUNT_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ARG_COUNT_BITS) - 64'd1);
  localparam logic [31:0] LenMask =
    (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LENGTH_BITS) - 64'd1);

  phase_e          phase_q, phase_d;
  logic [NumW-1:0] acc_q, acc_d;
  logic            seen_q, seen_d;
  logic [CntW-1:0] expected_q, expected_d;
  logic [CntW-1:0] done_q, done_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [31:0]     cbc_q, cbc_d;

  logic            is_break, is_digit, is_star, is_dollar;
  logic [31:0]     arg_lim, len_lim, lim;
  logic [VW-1:0]   num_v;
  logic            over, num_err, num_done;
  err_code_e       num_code;
  logic [31:0]     cbc_inc;
  logic [LenW-1:0] rem_dec;
  logic [CntW-1:0] done_inc;
  logic            arg_end, cmd_end, is_payload;

  assign is_break  = (byte_i == CHAR_LF) || (byte_i == CHAR_CR);
  assign is_digit  = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign is_star   = (byte_i == CHAR_STAR);
  assign is_dollar = (byte_i == CHAR_DOLLAR);

  assign arg_lim = 32'(cfg_i.max_arguments) & ArgMask;
  assign len_lim = 32'(cfg_i.max_payload_length) & LenMask;
  assign lim     = (phase_q == PH_COUNT) ? arg_lim : len_lim;

  // acc * 10 + digit, compared against the active limit
  assign num_v    = VW'(acc_q) * VW'(10) + VW'(byte_i - CHAR_ZERO);
  assign over     = 40'(num_v) > 40'(lim);
  assign num_done = is_break && seen_q && (acc_q != '0);
  assign num_err  = (is_digit && over) || (is_break && seen_q && (acc_q == '0)) ||
                    (!is_digit && !is_break);
  assign num_code = is_digit ? ERR_LIMIT : ERR_NUMBER;

  assign cbc_inc    = (cbc_q == 32'hFFFF_FFFF) ? cbc_q : cbc_q + 32'd1;
  assign rem_dec    = (rem_q != '0) ? rem_q - LenW'(1) : rem_q;
  assign done_inc   = done_q + CntW'(1);
  assign arg_end    = (rem_dec == '0);
  assign cmd_end    = arg_end && (done_inc >= expected_q);
  assign is_payload = ((phase_q == PH_FIRST) && !is_break) || (phase_q == PH_PAYLOAD);

  // Next state
  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    seen_d     = seen_q;
    expected_d = expected_q;
    done_d     = done_q;
    rem_d      = rem_q;
    cbc_d      = cbc_inc;
    unique case (phase_q) inside
      PH_WAIT, PH_SKIP: begin
        cbc_d = cbc_q;
        if (is_star) begin
          phase_d = PH_COUNT;
          cbc_d   = 32'd1;
          done_d  = '0;
          acc_d   = '0;
          seen_d  = 1'b0;
        end else if ((phase_q == PH_WAIT) && !is_break) begin
          phase_d = PH_SKIP;
        end
      end
      PH_COUNT, PH_LENGTH: begin
        if (is_digit && !over) begin
          acc_d  = NumW'(num_v);
          seen_d = 1'b1;
        end else if (num_err) begin
          phase_d = PH_SKIP;
        end else if (num_done) begin
          if (phase_q == PH_COUNT) begin
            expected_d = CntW'(acc_q);
            done_d     = '0;
            phase_d    = PH_BULK;
          end else begin
            rem_d   = LenW'(acc_q);
            phase_d = PH_FIRST;
          end
        end
      end
      PH_BULK: begin
        if (is_dollar) begin
          acc_d   = '0;
          seen_d  = 1'b0;
          phase_d = PH_LENGTH;
        end else if (!is_break) begin
          phase_d = PH_SKIP;
        end
      end
      PH_FIRST, PH_PAYLOAD: begin
        if (is_payload) begin
          rem_d   = rem_dec;
          phase_d = PH_PAYLOAD;
          if (arg_end) begin
            done_d  = done_inc;
            phase_d = cmd_end ? PH_WAIT : PH_BULK;
          end
        end
      end
      default: phase_d = PH_SKIP;
    endcase
  end

  // Result for the current byte
  always_comb begin
    result_o = '0;
    unique case (phase_q) inside
      PH_WAIT: begin
        if (!is_star && !is_break) begin
          result_o.event_kind = EV_ERROR;
          result_o.error_code = ERR_BAD_ARRAY;
        end
      end
      PH_COUNT, PH_LENGTH: begin
        if (num_err) begin
          result_o.event_kind = EV_ERROR;
          result_o.error_code = num_code;
        end
      end
      PH_BULK: begin
        if (!is_dollar && !is_break) begin
          result_o.event_kind = EV_ERROR;
          result_o.error_code = ERR_BAD_BULK;
        end
      end
      PH_FIRST, PH_PAYLOAD: begin
        if (is_payload) begin
          result_o.event_kind     = EV_PAYLOAD;
          result_o.payload_byte   = byte_i;
          result_o.argument_index = 20'(done_q);
          result_o.argument_end   = arg_end;
          result_o.command_end    = cmd_end;
          if (cmd_end) begin
            result_o.argument_count = 20'(expected_q);
            result_o.command_length = cbc_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      acc_q      <= '0;
      seen_q     <= 1'b0;
      expected_q <= '0;
      done_q     <= '0;
      rem_q      <= '0;
      cbc_q      <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      seen_q     <= seen_d;
      expected_q <= expected_d;
      done_q     <= done_d;
      rem_q      <= rem_d;
      cbc_q      <= cbc_d;
    end
  end

  `RCP_ASSERT_NOW(a_rem_live, (phase_q == PH_FIRST) || (phase_q == PH_PAYLOAD),
                  rem_q != '0, "payload phase with no bytes left")
  `RCP_ASSERT_NOW(a_expected_live,
                  (phase_q == PH_BULK) || (phase_q == PH_LENGTH) ||
                  (phase_q == PH_FIRST) || (phase_q == PH_PAYLOAD),
                  expected_q != '0, "argument phase with zero expected count")
  `RCP_ASSERT_NOW(a_done_below,
                  (phase_q == PH_BULK) || (phase_q == PH_LENGTH) ||
                  (phase_q == PH_FIRST) || (phase_q == PH_PAYLOAD),
                  done_q < expected_q, "argument counter passed expected count")

endmodule

### rtl/core/resp_command_parser.sv
// resp_command_parser: byte-stream parser for array-of-bulk-string command records.
// Path: an accepted beat is held in the input register, its result in the result register.
// Throughput: one byte per cycle unless the result stalls; the parse step closes the state loop.
// Reset: rst_ni is asynchronous, active low; parser waits for '*'; argument limit max, payload limit 2^29.
// Depends on rcp_pkg, rcp_apb_regs, rcp_parser and resp_command_parser_macros.svh.
`timescale 1ns / 1ps
`include "resp_command_parser_macros.svh"

module resp_command_parser #(
  parameter int unsigned ARG_COUNT_BITS = 20,
  parameter int unsigned LENGTH_BITS    = 30
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
  // Result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] payload_byte, [27:8] argument_index, [47:28] argument_count,
  // [79:48] command_length, [81:80] error_code, [87:82] zero
  output logic [87:0]                 m_axis_tdata,
  output logic [2:0]                  m_axis_tuser,   // [1:0] event_kind, [2] argument_end
  output logic                        m_axis_tlast,   // command_end
  // Configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rcp_pkg::*;

  rcp_cfg_t    cfg;
  rcp_result_t step_res;

  // Input register: holds one accepted beat until the parser consumes it
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  // Result register
  logic        out_valid_q, out_valid_d;
  rcp_result_t out_q;

  logic        in_fire;
  logic        advance;

  // Advance the parser whenever an input beat is held and the result register is free or draining this cycle
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on the beat that moves into them
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  rcp_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcp_parser #(
    .ARG_COUNT_BITS (ARG_COUNT_BITS),
    .LENGTH_BITS    (LENGTH_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .cfg_i    (cfg),
    .result_o (step_res)
  );

  // Pack the result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.error_code, out_q.command_length,
                          out_q.argument_count, out_q.argument_index, out_q.payload_byte};
  assign m_axis_tuser  = {out_q.argument_end, out_q.event_kind};
  assign m_axis_tlast  = out_q.command_end;

  `RCP_ASSERT_NEXT(a_advance_shows, advance, out_valid_q,
                   "parsed beat did not reach the result register")
  `RCP_ASSERT_NOW(a_stall_holds, out_valid_q && !m_axis_tready, !advance,
                  "parser stepped while result register was blocked")
  `RCP_ASSERT_NOW(a_cmd_end_kind, m_axis_tvalid && m_axis_tlast,
                  m_axis_tuser[2] && (out_q.event_kind == EV_PAYLOAD),
                  "command end without payload argument end")

endmodule
